// File: rtl/date_time_advance_unit_defines.svh
`ifndef DATE_TIME_ADVANCE_UNIT_DEFINES_SVH
`define DATE_TIME_ADVANCE_UNIT_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define DTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// trigger in one cycle implies the consequence in the next
`define DTA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dta_pkg.sv
`default_nettype none

package dta_pkg;

  localparam int unsigned DateW     = 27;
  localparam int unsigned TimeInW   = 18;
  localparam int unsigned DayDeltaW = 16;
  localparam int unsigned SecDeltaW = 32;
  localparam int unsigned TimeOutW  = 17;

  typedef struct packed {
    logic [6:0] q;
    logic [6:0] r;
  } qr_t;

  // decode -> year step
  typedef struct packed {
    logic [DateW-1:0]    din;
    logic [TimeOutW-1:0] rem;
    logic [13:0]         y;
    logic                yok;
    logic [6:0]          m;
    logic [6:0]          dy;
    logic signed [17:0]  delta;
    logic signed [8:0]   dq;
  } dec_t;

  // year step -> month split and pack
  typedef struct packed {
    logic [DateW-1:0]    din;
    logic [TimeOutW-1:0] rem;
    logic [13:0]         y;
    logic [8:0]          jul;
    logic                leap;
    logic                ok;
  } yr_t;

  // floor(v / 100) for v below 12800
  function automatic logic [6:0] div100(input logic [13:0] v);
    logic [24:0] p;
    p = 25'(v[13:2]) * 25'd5243;
    return p[23:17];
  endfunction

  function automatic logic [8:0] cum_days(input logic [6:0] m);
    logic [8:0] c;
    case (m)
      7'd1:    c = 9'd0;
      7'd2:    c = 9'd31;
      7'd3:    c = 9'd59;
      7'd4:    c = 9'd90;
      7'd5:    c = 9'd120;
      7'd6:    c = 9'd151;
      7'd7:    c = 9'd181;
      7'd8:    c = 9'd212;
      7'd9:    c = 9'd243;
      7'd10:   c = 9'd273;
      7'd11:   c = 9'd304;
      7'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     n = 5'd30;
      7'd2:                                        n = leap ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

  // first day of month m minus one, as day of year
  function automatic logic [8:0] start_day(input logic [6:0] m, input logic leap);
    return cum_days(m) + {8'd0, (m > 7'd2) && leap};
  endfunction

  // year given as quotient and remainder by 100
  function automatic logic leap_qr(input qr_t v);
    return (v.r[1:0] == 2'b00) && ((v.r != 7'd0) || (v.q[1:0] == 2'b00));
  endfunction

  function automatic qr_t qr_inc(input qr_t v);
    qr_t n;
    if (v.r == 7'd99) begin
      n.r = 7'd0;
      n.q = v.q + 7'd1;
    end else begin
      n.r = v.r + 7'd1;
      n.q = v.q;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dta_if.sv
`default_nettype none

interface dta_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [dta_pkg::DateW-1:0]              date_in;
  logic signed [dta_pkg::TimeInW-1:0]     time_in;
  logic signed [dta_pkg::DayDeltaW-1:0]   day_delta;
  logic signed [dta_pkg::SecDeltaW-1:0]   second_delta;

  modport source (output valid, date_in, time_in, day_delta, second_delta, input ready);
  modport sink   (input valid, date_in, time_in, day_delta, second_delta, output ready);
endinterface

interface dta_out_if;
  logic                          valid;
  logic                          ready;
  logic [dta_pkg::DateW-1:0]     date_out;
  logic [dta_pkg::TimeOutW-1:0]  time_out;
  logic                          date_ok;

  modport source (output valid, date_out, time_out, date_ok, input ready);
  modport sink   (input valid, date_out, time_out, date_ok, output ready);
endinterface

`default_nettype wire

// File: rtl/dta_decode.sv
`default_nettype none

module dta_decode (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 adv_i,
  input  wire logic                                 valid_i,
  input  wire logic [dta_pkg::DateW-1:0]            date_in_i,
  input  wire logic signed [dta_pkg::TimeInW-1:0]   time_in_i,
  input  wire logic signed [dta_pkg::DayDeltaW-1:0] day_delta_i,
  input  wire logic signed [dta_pkg::SecDeltaW-1:0] second_delta_i,
  output logic                                      valid_o,
  output dta_pkg::dec_t                             dec_o
);

  localparam logic [27:0] RecipDay = 28'd203613265; // 2^37 / 675, rounded up
  localparam logic [26:0] DayBias  = 27'd44236800;  // 675 * 2^16
  localparam logic [23:0] Recip10k = 24'd13743896;  // 2^33 / 625, rounded up
  localparam logic [22:0] Recip100 = 23'd5368710;   // 2^27 / 25, rounded up
  localparam logic [17:0] Recip365 = 18'd183860;    // 2^26 / 365, rounded up

  // stage 1: seconds total and reciprocal products
  logic signed [17:0] t_eff;
  logic signed [32:0] tot_d;
  logic [26:0]        u_d;
  logic [54:0]        qp_d;
  logic [46:0]        yp_d;
  logic [44:0]        mp_d;

  logic               s1_valid_q;
  logic [26:0]        s1_din_q;
  logic signed [32:0] s1_tot_q;
  logic [16:0]        s1_q_q;
  logic [13:0]        s1_y10k_q;
  logic [17:0]        s1_y100_q;
  logic signed [15:0] s1_dd_q;

  assign t_eff = (time_in_i == -18'sd1) ? 18'sd0 : time_in_i;
  assign tot_d = 33'(t_eff) + 33'(second_delta_i);
  // floor by 128 first, then by 675 on a biased positive value
  assign u_d   = {tot_d[32], tot_d[32:7]} + DayBias;
  assign qp_d  = 55'(u_d) * 55'(RecipDay);
  assign yp_d  = 47'(date_in_i[26:4]) * 47'(Recip10k);
  assign mp_d  = 45'(date_in_i[23:2]) * 45'(Recip100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_din_q  <= date_in_i;
      s1_tot_q  <= tot_d;
      s1_q_q    <= qp_d[53:37];
      s1_y10k_q <= yp_d[46:33];
      s1_y100_q <= mp_d[44:27];
      s1_dd_q   <= day_delta_i;
    end
  end

  // stage 2: carry, remainder, date format split, total day shift
  logic signed [17:0] carry;
  logic signed [34:0] remf;
  logic               is_long;
  logic               is_mid;
  logic [16:0]        yw;
  logic [13:0]        part;
  logic signed [17:0] delta;

  logic               s2_valid_q;
  logic [26:0]        s2_din_q;
  logic [16:0]        s2_rem_q;
  logic [13:0]        s2_y_q;
  logic               s2_yok_q;
  logic               s2_long_q;
  logic [13:0]        s2_part_q;
  logic signed [17:0] s2_delta_q;
  logic [16:0]        s2_dabs_q;

  assign carry = $signed({1'b0, s1_q_q}) - 18'sd65536;
  assign remf  = 35'(s1_tot_q) - 35'(carry) * 35'sd86400;
  assign is_long = s1_din_q >= 27'd10000000;
  assign is_mid  = !is_long && (s1_din_q >= 27'd100000);
  assign delta   = 18'(s1_dd_q) + carry;

  always_comb begin
    if (is_long) begin
      yw   = 17'(s1_y10k_q);
      part = 14'(s1_din_q - 27'(s1_y10k_q) * 27'd10000);
    end else if (is_mid) begin
      yw   = s1_y100_q[16:0];
      part = 14'(s1_din_q - 27'(s1_y100_q) * 27'd100);
    end else begin
      yw   = s1_din_q[16:0];
      part = 14'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_din_q   <= s1_din_q;
      s2_rem_q   <= remf[16:0];
      s2_y_q     <= yw[13:0];
      s2_yok_q   <= (yw >= 17'd100) && (yw <= 17'd9999);
      s2_long_q  <= is_long;
      s2_part_q  <= part;
      s2_delta_q <= delta;
      s2_dabs_q  <= delta[17] ? 17'(-delta) : 17'(delta);
    end
  end

  // stage 3: month and day, whole years of the shift
  logic [6:0]        mq;
  logic [6:0]        dyl;
  logic [34:0]       dqp;
  logic [8:0]        dqa;
  dta_pkg::dec_t     dec_d;
  logic              dec_valid_q;
  dta_pkg::dec_t     dec_q;

  assign mq  = dta_pkg::div100(s2_part_q);
  assign dyl = 7'(s2_part_q - 14'(mq) * 14'd100);
  assign dqp = 35'(s2_dabs_q) * 35'(Recip365);
  assign dqa = dqp[34:26];

  always_comb begin
    dec_d.din   = s2_din_q;
    dec_d.rem   = s2_rem_q;
    dec_d.y     = s2_y_q;
    dec_d.yok   = s2_yok_q;
    dec_d.m     = s2_long_q ? mq : s2_part_q[6:0];
    dec_d.dy    = s2_long_q ? dyl : 7'd0;
    dec_d.delta = s2_delta_q;
    dec_d.dq    = s2_delta_q[17] ? -$signed(dqa) : $signed(dqa);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_valid_q <= 1'b0;
    end else if (adv_i) begin
      dec_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = dec_valid_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

// File: rtl/dta_yearstep.sv
`default_nettype none

module dta_yearstep (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           valid_i,
  input  wire dta_pkg::dec_t  dec_i,
  output logic                valid_o,
  output dta_pkg::yr_t        yr_o
);

  // stage 4: year estimate, day remainder, divide years by 100
  logic signed [9:0]  dr;
  logic signed [15:0] y2;
  logic [13:0]        z2;
  logic [13:0]        zy;

  logic               s4_valid_q;
  logic [26:0]        s4_din_q;
  logic [16:0]        s4_rem_q;
  logic [13:0]        s4_zy_q;
  logic [6:0]         s4_qy_q;
  logic [13:0]        s4_z2_q;
  logic [6:0]         s4_q2_q;
  logic [6:0]         s4_m_q;
  logic [6:0]         s4_dy_q;
  logic signed [9:0]  s4_dr_q;
  logic               s4_ok_q;

  assign dr = 10'($signed(dec_i.delta) - 18'($signed(dec_i.dq)) * 18'sd365);
  assign y2 = $signed({2'b00, dec_i.y}) + 16'($signed(dec_i.dq));
  assign z2 = 14'(y2 - 16'sd1);
  assign zy = dec_i.y - 14'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s4_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_din_q <= dec_i.din;
      s4_rem_q <= dec_i.rem;
      s4_zy_q  <= zy;
      s4_qy_q  <= dta_pkg::div100(zy);
      s4_z2_q  <= z2;
      s4_q2_q  <= dta_pkg::div100(z2);
      s4_m_q   <= dec_i.m;
      s4_dy_q  <= dec_i.dy;
      s4_dr_q  <= dr;
      // result years far outside the range are flagged not ok here
      s4_ok_q  <= dec_i.yok && (y2 >= 16'sd2) && (y2 <= 16'sd10005);
    end
  end

  // stage 5: leap flags, leap-day correction, input date check
  dta_pkg::qr_t       qry;
  dta_pkg::qr_t       qr2;
  dta_pkg::qr_t       qr2n;
  logic               leap_y;
  logic [12:0]        lt_y;
  logic [12:0]        lt_2;
  logic signed [12:0] jul;
  logic               fields_ok;

  logic               s5_valid_q;
  logic [26:0]        s5_din_q;
  logic [16:0]        s5_rem_q;
  logic [13:0]        s5_y2_q;
  logic signed [12:0] s5_jul_q;
  logic               s5_lm1_q;
  logic               s5_l0_q;
  logic               s5_lp1_q;
  logic               s5_ok_q;

  assign qry.q  = s4_qy_q;
  assign qry.r  = 7'(s4_zy_q - 14'(s4_qy_q) * 14'd100);
  assign qr2.q  = s4_q2_q;
  assign qr2.r  = 7'(s4_z2_q - 14'(s4_q2_q) * 14'd100);
  assign qr2n   = dta_pkg::qr_inc(qr2);
  assign leap_y = dta_pkg::leap_qr(dta_pkg::qr_inc(qry));

  // leap days through a year: y/4 - y/100 + y/400
  assign lt_y = 13'(s4_zy_q[13:2]) - 13'(s4_qy_q) + 13'(s4_qy_q[6:2]);
  assign lt_2 = 13'(s4_z2_q[13:2]) - 13'(s4_q2_q) + 13'(s4_q2_q[6:2]);

  assign jul = 13'(s4_dy_q) + 13'(dta_pkg::cum_days(s4_m_q))
             + {12'd0, (s4_m_q > 7'd2) && leap_y} + 13'(s4_dr_q) + lt_y - lt_2;

  assign fields_ok = ((s4_m_q == 7'd0) && (s4_dy_q == 7'd0))
                  || ((s4_m_q >= 7'd1) && (s4_m_q <= 7'd12)
                      && ((s4_dy_q == 7'd0)
                          || (s4_dy_q <= 7'(dta_pkg::month_len(s4_m_q, leap_y)))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (adv_i) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s5_din_q <= s4_din_q;
      s5_rem_q <= s4_rem_q;
      s5_y2_q  <= s4_z2_q + 14'd1;
      s5_jul_q <= jul;
      s5_lm1_q <= dta_pkg::leap_qr(qr2);
      s5_l0_q  <= dta_pkg::leap_qr(qr2n);
      s5_lp1_q <= dta_pkg::leap_qr(dta_pkg::qr_inc(qr2n));
      s5_ok_q  <= s4_ok_q && fields_ok;
    end
  end

  // stage 6: single wrap into the neighboring year, final range check
  logic signed [12:0] ylen0;
  logic [13:0]        y3;
  logic signed [12:0] j3;
  logic               l3;
  logic               ok6;
  dta_pkg::yr_t       yr_d;
  logic               yr_valid_q;
  dta_pkg::yr_t       yr_q;

  assign ylen0 = 13'sd365 + $signed({12'd0, s5_l0_q});

  always_comb begin
    if (s5_jul_q > ylen0) begin
      y3 = s5_y2_q + 14'd1;
      j3 = s5_jul_q - ylen0;
      l3 = s5_lp1_q;
    end else if (s5_jul_q < 13'sd1) begin
      y3 = s5_y2_q - 14'd1;
      j3 = s5_jul_q + 13'sd365 + $signed({12'd0, s5_lm1_q});
      l3 = s5_lm1_q;
    end else begin
      y3 = s5_y2_q;
      j3 = s5_jul_q;
      l3 = s5_l0_q;
    end
  end

  assign ok6 = s5_ok_q && (y3 >= 14'd100) && (y3 <= 14'd9999) && (j3 >= 13'sd1)
            && (j3 <= 13'sd365 + $signed({12'd0, l3}));

  always_comb begin
    yr_d.din  = s5_din_q;
    yr_d.rem  = s5_rem_q;
    yr_d.y    = y3;
    yr_d.jul  = j3[8:0];
    yr_d.leap = l3;
    yr_d.ok   = ok6;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yr_valid_q <= 1'b0;
    end else if (adv_i) begin
      yr_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      yr_q <= yr_d;
    end
  end

  assign valid_o = yr_valid_q;
  assign yr_o    = yr_q;

endmodule

`default_nettype wire

// File: rtl/dta_monthpack.sv
`default_nettype none

module dta_monthpack (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          valid_i,
  input  wire dta_pkg::yr_t                  yr_i,
  output logic                               valid_o,
  output logic [dta_pkg::DateW-1:0]          date_out_o,
  output logic [dta_pkg::TimeOutW-1:0]       time_out_o,
  output logic                               date_ok_o
);

  // stage 7: month search over the cumulative table, year scaled
  logic [6:0]  rm;
  logic [4:0]  rd;

  logic        s7_valid_q;
  logic [26:0] s7_din_q;
  logic [16:0] s7_rem_q;
  logic [26:0] s7_ymul_q;
  logic [6:0]  s7_rm_q;
  logic [4:0]  s7_rd_q;
  logic        s7_ok_q;

  always_comb begin
    rm = 7'd1;
    for (int i = 2; i <= 12; i++) begin
      if (yr_i.jul > dta_pkg::start_day(7'(i), yr_i.leap)) begin
        rm = 7'(i);
      end
    end
  end

  assign rd = 5'(yr_i.jul - dta_pkg::start_day(rm, yr_i.leap));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (adv_i) begin
      s7_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s7_din_q  <= yr_i.din;
      s7_rem_q  <= yr_i.rem;
      s7_ymul_q <= 27'(yr_i.y) * 27'd10000;
      s7_rm_q   <= rm;
      s7_rd_q   <= rd;
      s7_ok_q   <= yr_i.ok;
    end
  end

  // stage 8: packed decimal result into the output register
  logic [26:0] packed_date;
  logic        out_valid_q;
  logic [26:0] date_q;
  logic [16:0] time_q;
  logic        ok_q;

  assign packed_date = s7_ymul_q + 27'(s7_rm_q) * 27'd100 + 27'(s7_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      date_q <= s7_ok_q ? packed_date : s7_din_q;
      time_q <= s7_rem_q;
      ok_q   <= s7_ok_q;
    end
  end

  assign valid_o    = out_valid_q;
  assign date_out_o = date_q;
  assign time_out_o = time_q;
  assign date_ok_o  = ok_q;

endmodule

`default_nettype wire

// File: rtl/date_time_advance_unit.sv
// date and time advance unit
// in_i carries a packed decimal date (YYYYMMDD, YYYYMM or YYYY), a time of day
// in seconds (-1 for no time), a day shift and a second shift. out_o returns
// the shifted full date YYYYMMDD, the time of day in 0..86399 and date_ok.
// when the input date is invalid or the result year leaves 100..9999 the
// input date is returned with date_ok low; the time is reduced in any case.
// a transfer on either channel happens when valid and ready are both high.
// the result of an input transfer shows on out_o after passing every stage;
// an eight-stage pipeline takes one item in every cycle while out_o is not
// stalled, so sustained throughput is one item per clock.
// when out_o is held valid and not ready, every stage holds and in_i.ready
// drops in the same cycle; nothing is lost or repeated and the pipeline
// moves again as soon as the result is taken.
// reset clears all stage valid bits; the block keeps no state between items.
`default_nettype none
`include "date_time_advance_unit_defines.svh"

module date_time_advance_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dta_in_if.sink    in_i,
  dta_out_if.source out_o
);

  logic          adv;
  logic          dec_valid;
  dta_pkg::dec_t dec;
  logic          yr_valid;
  dta_pkg::yr_t  yr;
  logic          out_valid;

  // whole pipeline moves unless a finished result is waiting
  assign adv        = !out_valid || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid = out_valid;

  dta_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (in_i.valid),
    .date_in_i      (in_i.date_in),
    .time_in_i      (in_i.time_in),
    .day_delta_i    (in_i.day_delta),
    .second_delta_i (in_i.second_delta),
    .valid_o        (dec_valid),
    .dec_o          (dec)
  );

  dta_yearstep u_yearstep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dec_valid),
    .dec_i   (dec),
    .valid_o (yr_valid),
    .yr_o    (yr)
  );

  dta_monthpack u_monthpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (yr_valid),
    .yr_i       (yr),
    .valid_o    (out_valid),
    .date_out_o (out_o.date_out),
    .time_out_o (out_o.time_out),
    .date_ok_o  (out_o.date_ok)
  );

  `DTA_ASSERT(a_time_in_day, out_valid |-> (out_o.time_out < 17'd86400), "time out of day range")
  `DTA_ASSERT(a_ok_date_range, (out_valid && out_o.date_ok) |-> ((out_o.date_out >= 27'd1000101) && (out_o.date_out <= 27'd99991231)), "valid date outside year range")
  `DTA_ASSERT_NEXT(a_stall_holds_item, !adv && dec_valid, dec_valid, "item lost inside stalled pipeline")

endmodule

`default_nettype wire

// File: test/date_time_advance_unit_tb.sv
module date_time_advance_unit_tb;

  localparam int unsigned DateW     = dta_pkg::DateW;
  localparam int unsigned TimeInW   = dta_pkg::TimeInW;
  localparam int unsigned DayDeltaW = dta_pkg::DayDeltaW;
  localparam int unsigned SecDeltaW = dta_pkg::SecDeltaW;
  localparam int unsigned TimeOutW  = dta_pkg::TimeOutW;

  typedef struct {
    logic [DateW-1:0]            date_in;
    logic signed [TimeInW-1:0]   time_in;
    logic signed [DayDeltaW-1:0] day_delta;
    logic signed [SecDeltaW-1:0] second_delta;
  } shift_req_t;

  typedef struct {
    logic [DateW-1:0]    date_out;
    logic [TimeOutW-1:0] time_out;
    logic                date_ok;
  } shift_res_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int          HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dta_in_if  req_ch ();
  dta_out_if res_ch ();

  date_time_advance_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (res_ch.source)
  );

  always #10 clk_i = ~clk_i;

  shift_req_t pending_q[$];
  shift_res_t expected_q[$];
  int         send_idle_pct = 16;
  int         recv_idle_pct = 73;
  bit         hold_go = 1'b0;
  int         hold_cnt = 0;
  int         mismatches = 0;
  int         cycle_cnt = 0;

  function automatic bit is_leap(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint leaps_upto(longint y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic longint days_in_year(longint y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic longint days_in_month(longint m, longint y);
    longint lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2) return is_leap(y) ? 29 : 28;
    return lens[m];
  endfunction

  function automatic shift_res_t shift_date(shift_req_t r);
    longint cum[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    shift_res_t res;
    longint t, tot, carry, rem, y, m, dy, delta, jul, y2, len;
    longint unsigned din;
    bit ok, done;
    din = r.date_in;
    t = r.time_in;
    if (t == -1) t = 0;
    tot = t + longint'(r.second_delta);
    carry = tot / 86400;
    rem = tot - carry * 86400;
    if (rem < 0) begin
      rem += 86400;
      carry -= 1;
    end
    if (din >= 10000000) begin
      y = din / 10000; m = (din % 10000) / 100; dy = din % 100;
    end else if (din >= 100000) begin
      y = din / 100; m = din % 100; dy = 0;
    end else begin
      y = din; m = 0; dy = 0;
    end
    ok = (y >= 100 && y <= 9999);
    if (ok && !(m == 0 && dy == 0)) begin
      if (m < 1 || m > 12) ok = 1'b0;
      else if (dy != 0 && dy > days_in_month(m, y)) ok = 1'b0;
    end
    res.date_out = r.date_in;
    res.time_out = TimeOutW'(rem);
    res.date_ok = 1'b0;
    if (ok) begin
      delta = longint'(r.day_delta) + carry;
      jul = dy + cum[m] + ((m > 2 && is_leap(y)) ? 1 : 0);
      y2 = y + delta / 365;
      jul += delta % 365;
      jul = jul - leaps_upto(y2 - 1) + leaps_upto(y - 1);
      if (jul > days_in_year(y2)) begin
        jul -= days_in_year(y2);
        y2 += 1;
      end else if (jul < 1) begin
        y2 -= 1;
        jul += days_in_year(y2);
      end
      if (y2 >= 100 && y2 <= 9999 && jul >= 1 && jul <= days_in_year(y2)) begin
        done = 1'b0;
        m = 12; dy = 31;
        for (int i = 1; i <= 12; i++) begin
          len = days_in_month(i, y2);
          if (!done) begin
            if (jul > len) jul -= len;
            else begin
              m = i; dy = jul; done = 1'b1;
            end
          end
        end
        res.date_out = DateW'(y2 * 10000 + m * 100 + dy);
        res.date_ok = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic shift_req_t make_req(longint d, longint t, longint dd, longint sd);
    shift_req_t r;
    r.date_in = DateW'(d);
    r.time_in = TimeInW'(t);
    r.day_delta = DayDeltaW'(dd);
    r.second_delta = SecDeltaW'(sd);
    return r;
  endfunction

  // mostly well-formed dates, some partial, some broken, some raw bit noise
  function automatic shift_req_t rand_req();
    shift_req_t r;
    longint y, m, d, t, sd;
    int pick;
    pick = $urandom_range(0, 99);
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999) : $urandom_range(100, 9999);
    if ($urandom_range(0, 5) == 0) y = ($urandom_range(0, 1) != 0) ? 9999 : 100;
    m = $urandom_range(1, 12);
    d = $urandom_range(1, days_in_month(m, y));
    if (pick < 60) r.date_in = DateW'(y * 10000 + m * 100 + d);
    else if (pick < 68) r.date_in = DateW'(y * 100 + $urandom_range(0, 12));
    else if (pick < 74) r.date_in = DateW'(y);
    else if (pick < 84) r.date_in = DateW'(y * 10000 + $urandom_range(0, 15) * 100
                                           + $urandom_range(0, 35));
    else r.date_in = DateW'($urandom);
    t = $urandom_range(0, 86399);
    pick = $urandom_range(0, 9);
    if (pick == 0) t = -1;
    else if (pick == 1) t = $urandom;
    r.time_in = TimeInW'(t);
    r.day_delta = DayDeltaW'($urandom);
    if ($urandom_range(0, 2) == 0) r.day_delta = DayDeltaW'($urandom_range(0, 800) - 400);
    pick = $urandom_range(0, 3);
    if (pick == 0) sd = $urandom_range(0, 200000) - 100000;
    else if (pick == 1) sd = 0;
    else sd = $signed($urandom);
    r.second_delta = SecDeltaW'(sd);
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.date_in <= '0;
      req_ch.time_in <= '0;
      req_ch.day_delta <= '0;
      req_ch.second_delta <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_q.push_back(shift_date(pending_q.pop_front()));
      end
      if ((!req_ch.valid || req_ch.ready) && pending_q.size() > 0
          && ($urandom_range(0, 99) >= send_idle_pct)) begin
        req_ch.valid <= 1'b1;
        req_ch.date_in <= pending_q[0].date_in;
        req_ch.time_in <= pending_q[0].time_in;
        req_ch.day_delta <= pending_q[0].day_delta;
        req_ch.second_delta <= pending_q[0].second_delta;
      end else if (req_ch.valid && req_ch.ready) begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // long hold-off length
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt < HoldCycles) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_go && hold_cnt < HoldCycles) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    shift_res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: date %0d", res_ch.date_out);
      end else begin
        want = expected_q.pop_front();
        if (res_ch.date_out !== want.date_out || res_ch.time_out !== want.time_out
            || res_ch.date_ok !== want.date_ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0b got %0d %0d %0b", want.date_out,
                     want.time_out, want.date_ok, res_ch.date_out, res_ch.time_out,
                     res_ch.date_ok);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || req_ch.valid) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, partial dates, invalid dates, leap days, year range
    pending_q.push_back(make_req(20240229, 0, 0, 0));
    pending_q.push_back(make_req(20230228, 86399, 0, 1));
    pending_q.push_back(make_req(20001231, -1, 1, 0));
    pending_q.push_back(make_req(19000301, 0, -1, 0));
    pending_q.push_back(make_req(2024, 0, 0, 0));
    pending_q.push_back(make_req(202403, 0, 0, 0));
    pending_q.push_back(make_req(100, 0, 0, 0));
    pending_q.push_back(make_req(1000101, 0, -1, 0));
    pending_q.push_back(make_req(99991231, 86399, 0, 1));
    pending_q.push_back(make_req(99991231, 0, 32767, 2147483647));
    pending_q.push_back(make_req(1000101, 0, -32768, -2147483648));
    pending_q.push_back(make_req(20230229, 0, 0, 0));
    pending_q.push_back(make_req(20231301, 0, 0, 0));
    pending_q.push_back(make_req(20230015, 0, 0, 0));
    pending_q.push_back(make_req(99, 0, 0, 0));
    pending_q.push_back(make_req(134217727, 131071, 0, 0));
    pending_q.push_back(make_req(20230101, -131072, 0, 0));
    pending_q.push_back(make_req(20230101, -2, 0, 0));
    pending_q.push_back(make_req(20230101, 100000, 0, 0));
    pending_q.push_back(make_req(50000615, 43200, -32768, 2147483647));
    pending_q.push_back(make_req(50000615, 43200, 32767, -2147483648));
    pending_q.push_back(make_req(99990100, 0, 0, 0));
    for (int i = 0; i < 280; i++) pending_q.push_back(rand_req());
    drain();
    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 60; i++) pending_q.push_back(rand_req());
    drain();
    send_idle_pct = 73;
    recv_idle_pct = 16;
    for (int i = 0; i < 250; i++) pending_q.push_back(rand_req());
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 260; i++) pending_q.push_back(rand_req());
    drain();
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/dta_pkg.sv
rtl/dta_if.sv
rtl/dta_decode.sv
rtl/dta_yearstep.sv
rtl/dta_monthpack.sv
rtl/date_time_advance_unit.sv
test/date_time_advance_unit_tb.sv
